// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dws_pkg.sv -----
package dws_pkg;

  // Command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_INSERT     = 3'd4;
  localparam logic [2:0] CMD_ERASE      = 3'd5;
  localparam logic [2:0] CMD_FIND       = 3'd6;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [4:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic               found;
    logic [3:0]         found_index;
    logic [4:0]         entry_count;
  } rsp_t;

  // Shift applied to the whole cell row
  typedef enum logic [1:0] {
    SH_NONE,
    SH_OPEN,
    SH_CLOSE
  } shift_t;

  typedef struct packed {
    shift_t shift;
    logic   cmp_en;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

endpackage

// ----- sv/dws_cell.sv -----
// One slot of the list: shifts toward either neighbor and compares with the key.
module dws_cell #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32,
  parameter int INDEX      = 0,
  localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  dws_pkg::cell_ctrl_t    ctrl,
  input  logic [IW-1:0]          pos,
  input  logic [VALUE_BITS-1:0]  operand,
  input  logic [VALUE_BITS-1:0]  prev_data,
  input  logic [VALUE_BITS-1:0]  next_data,
  input  logic                   live,
  output logic [VALUE_BITS-1:0]  data,
  output logic                   match
);
  import dws_pkg::*;

  localparam logic [IW-1:0] IDX = IW'(INDEX);

  logic [VALUE_BITS-1:0] data_next;

  // Open a gap at pos (shift toward back) or close it (shift toward front)
  always_comb begin
    data_next = data;
    unique case (ctrl.shift)
      SH_OPEN: begin
        if (IDX > pos) begin
          data_next = prev_data;
        end else if (IDX == pos) begin
          data_next = operand;
        end
      end
      SH_CLOSE: begin
        if (IDX >= pos) begin
          data_next = next_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (ctrl.cmp_en) begin
      match <= live && (data == operand);
    end
  end

endmodule

// ----- sv/deque_with_search.sv -----
// Bounded deque of DEPTH signed entries with positional insert/erase and
// first-match search. Every command passes through these steps: the request
// is accepted, then the whole cell row shifts or every live cell compares
// against the key, and then the first match is resolved and the response
// register is loaded. A new request is accepted as soon as the previous one
// has reached the response register, even while that response still waits
// to be taken; the final step stretches only while the response register is
// still full. Failing commands (empty, full, bad index) report a status and
// leave the list untouched. Entry storage is not reset; only the fill count,
// the state and the response valid flag are.
`include "assert_macros.svh"

module deque_with_search #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dws_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dws_pkg::rsp_t rsp
);
  import dws_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  state_t state, state_next;

  req_t                  req_q;
  logic [CW-1:0]         count, count_next;
  logic [1:0]            status_q, status_next;
  logic [VALUE_BITS-1:0] removed_q, removed_next;

  logic [VALUE_BITS-1:0] operand;
  logic [IW-1:0]         shift_pos;
  cell_ctrl_t            ctrl;
  logic [VALUE_BITS-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      match_vec;
  logic [DEPTH-1:0]      live_vec;

  logic                  accept;
  logic                  out_free;
  logic                  found_any;
  logic [IW-1:0]         found_idx;

  assign accept   = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;
  assign operand  = VALUE_BITS'(req_q.value);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    req_ready = (state == S_IDLE);
  end

  // Decode the command against the current fill count
  always_comb begin
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          full;
    logic          empty;
    pos_ext     = PW'(req_q.position);
    cnt_ext     = PW'(count);
    full        = (count == CW'(DEPTH));
    empty       = (count == '0);
    status_next = STAT_OK;
    shift_pos   = '0;
    count_next  = count;
    ctrl.shift  = SH_NONE;
    ctrl.cmp_en = 1'b0;
    if (state == S_EXEC) begin
      unique case (req_q.command)
        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
          if (full) begin
            status_next = STAT_FULL;
          end else if (req_q.command == CMD_INSERT && pos_ext > cnt_ext) begin
            status_next = STAT_RANGE;
          end else begin
            ctrl.shift = SH_OPEN;
            count_next = count + CW'(1);
            unique case (req_q.command)
              CMD_PUSH_FRONT: shift_pos = '0;
              CMD_PUSH_BACK:  shift_pos = count[IW-1:0];
              default:        shift_pos = pos_ext[IW-1:0];
            endcase
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
          if (empty) begin
            status_next = STAT_EMPTY;
          end else if (req_q.command == CMD_ERASE && pos_ext >= cnt_ext) begin
            status_next = STAT_RANGE;
          end else begin
            ctrl.shift = SH_CLOSE;
            count_next = count - CW'(1);
            unique case (req_q.command)
              CMD_POP_FRONT: shift_pos = '0;
              CMD_POP_BACK:  shift_pos = IW'(count - CW'(1));
              default:       shift_pos = pos_ext[IW-1:0];
            endcase
          end
        end
        CMD_FIND: ctrl.cmp_en = 1'b1;
        default: ;
      endcase
    end
  end

  // Pick out the value leaving the row
  always_comb begin
    removed_next = '0;
    if (ctrl.shift == SH_CLOSE) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (IW'(i) == shift_pos) removed_next = removed_next | cell_data[i];
      end
    end
  end

  // Cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_BITS-1:0] prev_d;
    logic [VALUE_BITS-1:0] next_d;
    if (g == 0) begin : g_first
      assign prev_d = operand;
    end else begin : g_mid
      assign prev_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_d = cell_data[g];
    end else begin : g_inner
      assign next_d = cell_data[g+1];
    end
    assign live_vec[g] = (CW'(g) < count);

    dws_cell #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .INDEX      (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (shift_pos),
      .operand   (operand),
      .prev_data (prev_d),
      .next_data (next_d),
      .live      (live_vec[g]),
      .data      (cell_data[g]),
      .match     (match_vec[g])
    );
  end

  // First match from the front
  always_comb begin
    found_any = 1'b0;
    found_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        found_any = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request and response payload
  always_ff @(posedge clk) begin
    if (accept) req_q <= req;
    if (state == S_EXEC) begin
      status_q  <= status_next;
      removed_q <= removed_next;
    end
    if (state == S_DONE && out_free) begin
      rsp.status        <= status_q;
      rsp.removed_value <= 32'(removed_q);
      rsp.found         <= (req_q.command == CMD_FIND) && found_any;
      rsp.found_index   <= (req_q.command == CMD_FIND && found_any) ? 4'(found_idx) : 4'd0;
      rsp.entry_count   <= 5'(count);
    end
  end

  // Checks
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "fill count above depth")
  `ASSERT_NEXT(a_count_hold, clk, rst, state != S_EXEC, $stable(count), "count moved outside exec")
  `ASSERT_NEXT(a_open_inc, clk, rst, ctrl.shift == SH_OPEN, count == $past(count) + CW'(1),
               "open without count increment")
  `ASSERT_NEXT(a_rsp_load, clk, rst, state == S_DONE && out_free, rsp_valid && state == S_IDLE,
               "response not posted")

endmodule

// ----- dv/tb_deque_with_search.sv -----
module tb_deque_with_search;
  timeunit 1ns;
  timeprecision 1ps;

  import dws_pkg::*;

  localparam int         LIST_DEPTH  = 16;
  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam int         RANDOM_REQS = 400;
  localparam int         CALM_REQS   = 60;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req       = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  // Mirror of the list contents, front at index 0
  logic signed [31:0] list_mirror[$];
  // Responses still owed by the block, oldest first
  rsp_t               owed_rsp[$];
  int                 error_count = 0;
  int                 idle_pct    = 25;
  int                 stall_left  = 0;

  deque_with_search u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // Apply one command to the mirror and return the response it must produce
  function automatic rsp_t apply_command(req_t r);
    rsp_t o;
    int   n;
    o = '0;
    n = list_mirror.size();
    case (r.command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (n >= LIST_DEPTH) begin
          o.status = STAT_FULL;
        end else if (r.command == CMD_PUSH_FRONT) begin
          list_mirror.push_front(r.value);
        end else if (r.command == CMD_PUSH_BACK || r.position == n) begin
          list_mirror.push_back(r.value);
        end else if (r.position > n) begin
          o.status = STAT_RANGE;
        end else begin
          list_mirror.insert(r.position, r.value);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
        if (n == 0) begin
          o.status = STAT_EMPTY;
        end else if (r.command == CMD_POP_FRONT) begin
          o.removed_value = list_mirror.pop_front();
        end else if (r.command == CMD_POP_BACK) begin
          o.removed_value = list_mirror.pop_back();
        end else if (r.position >= n) begin
          o.status = STAT_RANGE;
        end else begin
          o.removed_value = list_mirror[r.position];
          list_mirror.delete(r.position);
        end
      end
      CMD_FIND: begin
        for (int i = 0; i < n; i++) begin
          if (list_mirror[i] == r.value) begin
            o.found       = 1'b1;
            o.found_index = 4'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    o.entry_count = 5'(list_mirror.size());
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Send one request; entered and left at a falling edge
  task automatic send_request(input logic [2:0] cmd, input logic signed [31:0] val,
                              input logic [4:0] pos);
    req_t item;
    item.command  = cmd;
    item.value    = val;
    item.position = pos;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    owed_rsp.push_back(apply_command(item));
    @(negedge clk);
  endtask

  // Response side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 4);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Compare each taken response with the oldest owed one
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (owed_rsp.size() == 0) begin
        report_mismatch("unrequested response, entry_count", rsp.entry_count, -1);
      end else begin
        want = owed_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.removed_value !== want.removed_value)
          report_mismatch("removed_value", rsp.removed_value, want.removed_value);
        if (rsp.found !== want.found)
          report_mismatch("found", rsp.found, want.found);
        if (rsp.found_index !== want.found_index)
          report_mismatch("found_index", rsp.found_index, want.found_index);
        if (rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", rsp.entry_count, want.entry_count);
      end
    end
  end

  // Every removal and search on an empty list, plus the unused code
  task automatic test_empty_list();
    send_request(CMD_POP_FRONT, 32'sd0, 5'd0);
    send_request(CMD_POP_BACK, 32'sd0, 5'd0);
    send_request(CMD_ERASE, 32'sd0, 5'd0);
    send_request(CMD_FIND, 32'sd0, 5'd0);
    send_request(CMD_UNUSED, -32'sd1, 5'd31);
  endtask

  // Value extremes, insert at the back position, out-of-range indexes
  task automatic test_push_insert();
    send_request(CMD_PUSH_BACK, 32'sh7fffffff, 5'd0);
    send_request(CMD_PUSH_FRONT, 32'sh80000000, 5'd31);
    send_request(CMD_INSERT, 32'sd0, 5'd2);
    send_request(CMD_INSERT, 32'sd5, 5'd5);
    send_request(CMD_ERASE, 32'sd0, 5'd3);
  endtask

  // One hit and one miss
  task automatic test_find();
    send_request(CMD_FIND, 32'sh7fffffff, 5'd0);
    send_request(CMD_FIND, 32'sd12345, 5'd0);
  endtask

  // Fill to capacity with duplicates, hit the full checks, then search and erase
  task automatic test_full_list();
    while (list_mirror.size() < LIST_DEPTH)
      send_request(CMD_PUSH_BACK, -32'sd1, 5'd0);
    send_request(CMD_PUSH_FRONT, 32'sd1, 5'd0);
    send_request(CMD_INSERT, 32'sd1, 5'd16);
    send_request(CMD_FIND, -32'sd1, 5'd0);
    send_request(CMD_ERASE, 32'sd0, 5'd1);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh80000000;
      1:       return 32'sh7fffffff;
      2:       return -32'sd1;
      3, 4:    return 32'($urandom_range(0, 7));
      5, 6:    return (list_mirror.size() > 0) ?
                      list_mirror[$urandom_range(0, list_mirror.size() - 1)] :
                      32'($urandom);
      default: return 32'($urandom);
    endcase
  endfunction

  // Random walk that swings between empty and full
  task automatic test_random(input int count, input bit calm);
    logic [2:0] cmd;
    logic [4:0] pos;
    int         r;
    int         n;
    bit         growing;
    growing = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (calm)
        idle_pct = 0;
      else if (k % 50 == 0)
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      n = list_mirror.size();
      if (n == LIST_DEPTH) growing = 1'b0;
      if (n == 0)          growing = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3)
        cmd = CMD_UNUSED;
      else if (r < 20)
        cmd = CMD_FIND;
      else if ((r < 75) == growing)
        cmd = ($urandom_range(0, 2) == 0) ? CMD_PUSH_FRONT :
              ($urandom_range(0, 1) == 0) ? CMD_PUSH_BACK : CMD_INSERT;
      else
        cmd = ($urandom_range(0, 2) == 0) ? CMD_POP_FRONT :
              ($urandom_range(0, 1) == 0) ? CMD_POP_BACK : CMD_ERASE;
      // Mostly legal indexes, sometimes anything the field holds
      if ($urandom_range(0, 4) == 0)
        pos = 5'($urandom_range(0, 31));
      else if (cmd == CMD_ERASE && n > 0)
        pos = 5'($urandom_range(0, n - 1));
      else
        pos = 5'($urandom_range(0, n));
      send_request(cmd, pick_value(), pos);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_push_insert();
    test_find();
    test_full_list();
    test_random(RANDOM_REQS - CALM_REQS, 1'b0);
    test_random(CALM_REQS, 1'b1);
    req_valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (owed_rsp.size() != 0 || error_count != 0) begin
      $display("deque_with_search test failed");
    end else begin
      $display("deque_with_search test passed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("deque_with_search test failed");
    $finish;
  end

endmodule
